// ===== rtl/core/ssfs_pkg.sv =====
package ssfs_pkg;

  // Time and accumulator widths
  localparam int TIME_BITS = 24;
  localparam int ACC_W     = TIME_BITS + 1;

  // Sheet geometry
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int CNT_W       = 7;
  localparam int FRAME_W     = 12;
  localparam int TOTAL_W     = 13;
  localparam int CUT_W       = 12;

  // Q1.16 edges
  localparam int Q_FRAC = 16;
  localparam int Q_W    = Q_FRAC + 1;
  localparam logic [Q_W-1:0] Q_ONE = {1'b1, {Q_FRAC{1'b0}}};

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TIME_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_FRAMES     = 3'd4;

  localparam logic [TIME_BITS-1:0] FRAME_DURATION_RST = 24'd33333;

  // Command codes
  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PLAY   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PAUSE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESUME = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STOP   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESET  = 3'd5;

  // Shared divider: quotient bits, divisor bits, dividend bits
  localparam int DIV_Q_W = Q_W;
  localparam int DIV_D_W = TOTAL_W;
  localparam int DIV_N_W = CNT_W + DIV_Q_W;
  localparam int STEP_W  = $clog2(DIV_Q_W);

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [TIME_BITS-1:0] delta_time;
    logic                 loop_request;
    logic                 notify_request;
  } ssfs_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [Q_W-1:0]     u_start;
    logic [Q_W-1:0]     v_start;
    logic [Q_W-1:0]     u_end;
    logic [Q_W-1:0]     v_end;
    logic               is_playing;
    logic               is_paused;
    logic               end_event;
  } ssfs_out_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] frame_duration;
    logic [TIME_BITS-1:0] loop_gap;
    logic [CNT_W-1:0]     column_count;
    logic [CNT_W-1:0]     row_count;
    logic [TOTAL_W-1:0]   frame_total;
  } ssfs_cfg_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } ssfs_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
    logic [DIV_D_W-1:0] remainder;
  } ssfs_div_rsp_t;

endpackage

// ===== rtl/core/ssfs_divider.sv =====
module ssfs_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ssfs_pkg::ssfs_div_req_t req_i,
  output ssfs_pkg::ssfs_div_rsp_t rsp_o
);
  import ssfs_pkg::*;

  // Restoring divider, one quotient bit per cycle. The caller keeps the
  // dividend's upper part below the divisor.
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_Q_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [DIV_D_W-1:0]  rem_r;
  logic [DIV_D_W-1:0]  divisor_r;
  logic [DIV_Q_W-1:0]  quot_r;
  logic [DIV_D_W+1:0]  trial;
  logic                borrow;
  logic [DIV_D_W-1:0]  rem_step;

  always_comb begin
    trial    = {1'b0, rem_r, quot_r[DIV_Q_W-1]} - {2'b00, divisor_r};
    borrow   = trial[DIV_D_W+1];
    rem_step = borrow ? {rem_r[DIV_D_W-2:0], quot_r[DIV_Q_W-1]} : trial[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rem_r     <= DIV_D_W'(req_i.dividend[DIV_N_W-1:DIV_Q_W]);
      quot_r    <= req_i.dividend[DIV_Q_W-1:0];
      divisor_r <= req_i.divisor;
    end else if (busy_r) begin
      rem_r  <= rem_step;
      quot_r <= {quot_r[DIV_Q_W-2:0], ~borrow};
    end
  end

  assign rsp_o.done      = done_r;
  assign rsp_o.quotient  = quot_r;
  assign rsp_o.remainder = rem_r;

endmodule

// ===== rtl/core/ssfs_cfg.sv =====
module ssfs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ssfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ssfs_pkg::ssfs_cfg_t               cfg_o
);
  import ssfs_pkg::*;

  logic [TIME_BITS-1:0] duration_r;
  logic [TIME_BITS-1:0] gap_r;
  logic [CNT_W-1:0]     cols_r;
  logic [CNT_W-1:0]     rows_r;
  logic [CUT_W-1:0]     cut_r;
  logic [TOTAL_W-1:0]   cells;
  logic [CUT_W-1:0]     cut_wr;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  always_comb begin
    cells  = TOTAL_W'(rows_r) * TOTAL_W'(cols_r);
    cut_wr = cfg_wdata[CUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= FRAME_DURATION_RST;
      gap_r      <= '0;
      cols_r     <= CNT_W'(1);
      rows_r     <= CNT_W'(1);
      cut_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_DURATION: duration_r <= cfg_wdata[TIME_BITS-1:0];
        CFG_LOOP_GAP:       gap_r      <= cfg_wdata[TIME_BITS-1:0];
        CFG_COLUMN_COUNT:
          cols_r <= clamp_count(cfg_wdata[CNT_W-1:0], CNT_W'(MAX_COLUMNS));
        CFG_ROW_COUNT:
          rows_r <= clamp_count(cfg_wdata[CNT_W-1:0], CNT_W'(MAX_ROWS));
        // drop a cut that would leave no frame
        CFG_CUT_FRAMES: cut_r <= (TOTAL_W'(cut_wr) >= cells) ? '0 : cut_wr;
        default: ;
      endcase
    end
  end

  assign cfg_o.frame_duration = duration_r;
  assign cfg_o.loop_gap       = gap_r;
  assign cfg_o.column_count   = cols_r;
  assign cfg_o.row_count      = rows_r;
  // a cut made too large by later geometry writes acts as none
  assign cfg_o.frame_total    = (TOTAL_W'(cut_r) < cells) ? cells - TOTAL_W'(cut_r) : cells;

endmodule

// ===== rtl/core/sprite_sheet_frame_sequencer.sv =====
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    ssfs_in_t   (action, delta, loop, notify)
// out_      output     out_valid / out_ready  ssfs_out_t  (frame, UV box, status, end)
// cfg_      input      cfg_we, no wait        cfg_index, cfg_wdata
//
// One transaction in gives exactly one transaction out. Each division on the shared restoring
// divider runs through start, load, quotient-bit steps and done: a division splits the index
// into row and column, each UV edge under 1.0 takes a division (an edge at 1.0 skips it), and
// an index past the total adds a modulo division. Around these an item passes accept, decode,
// tick steps and hand-off. Reset (rst_n low, synchronous) clears playback, loads defaults.
// in_ready is high only between items; a result waits in the output register while the next
// item runs, and that item's hand-off holds until the register drains.
module sprite_sheet_frame_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ssfs_pkg::ssfs_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ssfs_pkg::ssfs_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [ssfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ssfs_pkg::*;

  localparam int NUM_EDGES = 4;
  localparam int EDGE_W    = $clog2(NUM_EDGES);
  localparam logic [EDGE_W-1:0] EDGE_U_START = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_V_START = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_U_END   = 2'd2;
  localparam logic [EDGE_W-1:0] EDGE_V_END   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_GAP_CHK,
    S_GAP_ADD,
    S_FRAME,
    S_MOD,
    S_SPLIT,
    S_SPLIT_WAIT,
    S_RATIO,
    S_RATIO_WAIT,
    S_DONE
  } state_t;

  ssfs_cfg_t     cfg;
  ssfs_div_req_t div_req_r, div_req_nxt;
  ssfs_div_rsp_t div_rsp;

  state_t             state_r, state_nxt;
  ssfs_in_t           item_r, item_nxt;
  logic [ACC_W-1:0]   frame_acc_r, frame_acc_nxt;
  logic [ACC_W-1:0]   gap_acc_r, gap_acc_nxt;
  logic [FRAME_W-1:0] frame_ctr_r, frame_ctr_nxt;
  logic               in_gap_r, in_gap_nxt;
  logic               first_pass_r, first_pass_nxt;
  logic               running_r, running_nxt;
  logic               held_r, held_nxt;
  logic               repeat_r, repeat_nxt;
  logic               notify_r, notify_nxt;
  logic               ev_r, ev_nxt;
  logic [CNT_W-1:0]   col_r, col_nxt;
  logic [FRAME_W-1:0] row_r, row_nxt;
  logic [EDGE_W-1:0]  edge_r, edge_nxt;
  logic [Q_W-1:0]     ratio_r [NUM_EDGES];
  logic [Q_W-1:0]     ratio_nxt [NUM_EDGES];
  logic               out_valid_r, out_valid_nxt;
  ssfs_out_t          out_data_r, out_data_nxt;

  // datapath helpers
  logic [ACC_W:0]     gap_diff;
  logic [ACC_W:0]     frame_diff;
  logic [TOTAL_W-1:0] next_ctr;
  logic [TOTAL_W-1:0] edge_num;
  logic [CNT_W-1:0]   edge_den;
  logic               edge_sat;

  ssfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  ssfs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req_r),
    .rsp_o (div_rsp)
  );

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

  always_comb begin
    gap_diff   = {1'b0, gap_acc_r} - {1'b0, ACC_W'(cfg.loop_gap)};
    frame_diff = {1'b0, frame_acc_r} - {1'b0, ACC_W'(cfg.frame_duration)};
    next_ctr   = TOTAL_W'(frame_ctr_r) + TOTAL_W'(1);

    // pick numerator and denominator of the edge under work
    case (edge_r)
      EDGE_U_START: begin
        edge_num = TOTAL_W'(col_r);
        edge_den = cfg.column_count;
      end
      EDGE_V_START: begin
        edge_num = TOTAL_W'(row_r);
        edge_den = cfg.row_count;
      end
      EDGE_U_END: begin
        edge_num = TOTAL_W'(col_r) + TOTAL_W'(1);
        edge_den = cfg.column_count;
      end
      EDGE_V_END: begin
        edge_num = TOTAL_W'(row_r) + TOTAL_W'(1);
        edge_den = cfg.row_count;
      end
      default: begin
        edge_num = '0;
        edge_den = CNT_W'(1);
      end
    endcase
    // an edge at or past the sheet border is set to exactly 1.0
    edge_sat = edge_num >= TOTAL_W'(edge_den);
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    frame_acc_nxt  = frame_acc_r;
    gap_acc_nxt    = gap_acc_r;
    frame_ctr_nxt  = frame_ctr_r;
    in_gap_nxt     = in_gap_r;
    first_pass_nxt = first_pass_r;
    running_nxt    = running_r;
    held_nxt       = held_r;
    repeat_nxt     = repeat_r;
    notify_nxt     = notify_r;
    ev_nxt         = ev_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    edge_nxt       = edge_r;
    ratio_nxt      = ratio_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    div_req_nxt    = div_req_r;
    div_req_nxt.start = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          ev_nxt    = 1'b0;
          state_nxt = S_CMD;
        end
      end

      S_CMD: begin
        state_nxt = S_SPLIT;
        case (item_r.action)
          ACT_TICK: begin
            if (running_r) begin
              if (in_gap_r) begin
                gap_acc_nxt = sat_add(gap_acc_r, ACC_W'(item_r.delta_time));
                state_nxt   = S_GAP_CHK;
              end else begin
                frame_acc_nxt = sat_add(frame_acc_r, ACC_W'(item_r.delta_time));
                state_nxt     = S_FRAME;
              end
            end
          end
          ACT_PLAY: begin
            if (!running_r) begin
              frame_acc_nxt  = '0;
              gap_acc_nxt    = '0;
              frame_ctr_nxt  = '0;
              first_pass_nxt = 1'b1;
              in_gap_nxt     = 1'b0;
              running_nxt    = 1'b1;
              repeat_nxt     = item_r.loop_request;
              notify_nxt     = item_r.notify_request;
            end
          end
          ACT_PAUSE: begin
            if (running_r && !held_r) begin
              held_nxt    = 1'b1;
              running_nxt = 1'b0;
            end
          end
          ACT_RESUME: begin
            if (held_r) begin
              running_nxt = 1'b1;
              held_nxt    = 1'b0;
            end
          end
          ACT_STOP: begin
            if (running_r) begin
              frame_acc_nxt  = '0;
              gap_acc_nxt    = '0;
              frame_ctr_nxt  = '0;
              first_pass_nxt = 1'b1;
              in_gap_nxt     = 1'b0;
              running_nxt    = 1'b0;
              ev_nxt         = item_r.notify_request;
            end
          end
          ACT_RESET: begin
            frame_acc_nxt  = '0;
            gap_acc_nxt    = '0;
            frame_ctr_nxt  = '0;
            first_pass_nxt = 1'b1;
            in_gap_nxt     = 1'b0;
          end
          default: ;
        endcase
      end

      // hold in the gap until the gap time is used up
      S_GAP_CHK: begin
        if (gap_diff[ACC_W]) begin
          state_nxt = S_SPLIT;
        end else begin
          in_gap_nxt  = 1'b0;
          gap_acc_nxt = gap_diff[ACC_W-1:0];
          state_nxt   = S_GAP_ADD;
        end
      end

      // carry the gap overshoot into frame time
      S_GAP_ADD: begin
        frame_acc_nxt = sat_add(frame_acc_r, gap_acc_r);
        gap_acc_nxt   = '0;
        state_nxt     = S_FRAME;
      end

      // advance at most one frame
      S_FRAME: begin
        state_nxt = S_SPLIT;
        if (!frame_diff[ACC_W]) begin
          frame_acc_nxt = frame_diff[ACC_W-1:0];
          if (next_ctr == cfg.frame_total) begin
            if (first_pass_r && !repeat_r) begin
              // play-once pass is over: stop as for the stop command
              frame_acc_nxt  = '0;
              gap_acc_nxt    = '0;
              frame_ctr_nxt  = '0;
              first_pass_nxt = 1'b1;
              in_gap_nxt     = 1'b0;
              running_nxt    = 1'b0;
              ev_nxt         = notify_r;
            end else begin
              in_gap_nxt     = 1'b1;
              first_pass_nxt = 1'b0;
              frame_ctr_nxt  = '0;
            end
          end else if (next_ctr < cfg.frame_total) begin
            frame_ctr_nxt = next_ctr[FRAME_W-1:0];
          end else begin
            // index past the total after a geometry change: wrap by modulo
            div_req_nxt.start    = 1'b1;
            div_req_nxt.dividend = DIV_N_W'(next_ctr);
            div_req_nxt.divisor  = DIV_D_W'(cfg.frame_total);
            state_nxt            = S_MOD;
          end
        end
      end

      S_MOD: begin
        if (div_rsp.done) begin
          frame_ctr_nxt = div_rsp.remainder[FRAME_W-1:0];
          state_nxt     = S_SPLIT;
        end
      end

      // split the index into row and column
      S_SPLIT: begin
        div_req_nxt.start    = 1'b1;
        div_req_nxt.dividend = DIV_N_W'(frame_ctr_r);
        div_req_nxt.divisor  = DIV_D_W'(cfg.column_count);
        state_nxt            = S_SPLIT_WAIT;
      end

      S_SPLIT_WAIT: begin
        if (div_rsp.done) begin
          col_nxt   = div_rsp.remainder[CNT_W-1:0];
          row_nxt   = div_rsp.quotient[FRAME_W-1:0];
          edge_nxt  = EDGE_U_START;
          state_nxt = S_RATIO;
        end
      end

      // round(num / den) in Q1.16 as (num * 2^17 + den) / (2 * den)
      S_RATIO: begin
        if (edge_sat) begin
          ratio_nxt[edge_r] = Q_ONE;
          edge_nxt          = edge_r + 1'b1;
          if (edge_r == EDGE_V_END) state_nxt = S_DONE;
        end else begin
          div_req_nxt.start    = 1'b1;
          div_req_nxt.dividend = {edge_num[CNT_W-1:0], {DIV_Q_W{1'b0}}}
                                 + DIV_N_W'(edge_den);
          div_req_nxt.divisor  = DIV_D_W'({edge_den, 1'b0});
          state_nxt            = S_RATIO_WAIT;
        end
      end

      S_RATIO_WAIT: begin
        if (div_rsp.done) begin
          ratio_nxt[edge_r] = div_rsp.quotient;
          edge_nxt          = edge_r + 1'b1;
          state_nxt         = (edge_r == EDGE_V_END) ? S_DONE : S_RATIO;
        end
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.frame_number = frame_ctr_r;
          out_data_nxt.u_start      = ratio_r[EDGE_U_START];
          out_data_nxt.v_start      = ratio_r[EDGE_V_START];
          out_data_nxt.u_end        = ratio_r[EDGE_U_END];
          out_data_nxt.v_end        = ratio_r[EDGE_V_END];
          out_data_nxt.is_playing   = running_r;
          out_data_nxt.is_paused    = held_r;
          out_data_nxt.end_event    = ev_r;
          state_nxt                 = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frame_acc_r  <= '0;
      gap_acc_r    <= '0;
      frame_ctr_r  <= '0;
      in_gap_r     <= 1'b0;
      first_pass_r <= 1'b1;
      running_r    <= 1'b0;
      held_r       <= 1'b0;
      repeat_r     <= 1'b0;
      notify_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      div_req_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      frame_acc_r  <= frame_acc_nxt;
      gap_acc_r    <= gap_acc_nxt;
      frame_ctr_r  <= frame_ctr_nxt;
      in_gap_r     <= in_gap_nxt;
      first_pass_r <= first_pass_nxt;
      running_r    <= running_nxt;
      held_r       <= held_nxt;
      repeat_r     <= repeat_nxt;
      notify_r     <= notify_nxt;
      out_valid_r  <= out_valid_nxt;
      div_req_r    <= div_req_nxt;
    end
    item_r     <= item_nxt;
    ev_r       <= ev_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    edge_r     <= edge_nxt;
    ratio_r    <= ratio_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one item at a time: no second accept right after the first
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in work");

  // a loop gap only opens after a completed pass
  a_gap_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_gap_r |-> !first_pass_r)
    else $error("loop gap open during the first pass");

  a_gap_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    in_gap_r |-> (running_r || held_r))
    else $error("loop gap open on a stopped animation");

  a_end_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.end_event && out_data.is_playing))
    else $error("end event reported while still playing");

endmodule

// ===== dv/sprite_sheet_frame_sequencer_tb.sv =====
module sprite_sheet_frame_sequencer_tb;
  import ssfs_pkg::*;

  // Action codes the block must ignore; the package names only the six real ones.
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;
  // Register index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam logic [ACC_W-1:0] ACC_CEILING = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ssfs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ssfs_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sprite_sheet_frame_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the sheet registers, at their reset values.
  logic [TIME_BITS-1:0] sh_frame_dur = FRAME_DURATION_RST;
  logic [TIME_BITS-1:0] sh_loop_gap = '0;
  logic [CNT_W-1:0] sh_cols = 7'd1;
  logic [CNT_W-1:0] sh_rows = 7'd1;
  logic [CUT_W-1:0] sh_cut = '0;

  // Predicted playback state, at its reset values.
  logic [ACC_W-1:0] time_in_frame = '0;
  logic [ACC_W-1:0] time_in_gap = '0;
  logic [FRAME_W-1:0] cur_frame = '0;
  bit gap_active = 1'b0;
  bit on_first_pass = 1'b1;
  bit playing = 1'b0;
  bit paused = 1'b0;
  bit looping = 1'b0;
  bit notify_on_end = 1'b0;

  // Predicted frames, oldest first.
  ssfs_out_t frame_expect_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int items_sent = 0;
  int frames_checked = 0;
  int end_events = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("sprite_sheet_frame_sequencer verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] sum);
    return (sum > (ACC_W + 1)'(ACC_CEILING)) ? ACC_CEILING : sum[ACC_W-1:0];
  endfunction

  // Frames in one pass: all cells less the cut tail, the cut counting as
  // zero once the sheet has shrunk below it.
  function automatic logic [TOTAL_W-1:0] sheet_total();
    logic [TOTAL_W-1:0] cells;
    cells = TOTAL_W'(sh_rows) * TOTAL_W'(sh_cols);
    return (TOTAL_W'(sh_cut) < cells) ? cells - TOTAL_W'(sh_cut) : cells;
  endfunction

  // Q1.16 of num/den, rounded to nearest, clipped at 1.0.
  function automatic logic [Q_W-1:0] q16_edge(input int unsigned num, input int unsigned den);
    longint unsigned ratio;
    ratio = (64'(num) * 64'd131072 + 64'(den)) / (64'd2 * 64'(den));
    return (ratio > 64'(Q_ONE)) ? Q_ONE : Q_W'(ratio);
  endfunction

  function automatic void restart_pass();
    time_in_frame = '0;
    time_in_gap = '0;
    cur_frame = '0;
    on_first_pass = 1'b1;
    gap_active = 1'b0;
  endfunction

  // Advance the clock by one tick; return 1 when a play-once pass ends with
  // notification requested.
  function automatic bit advance_clock(input logic [TIME_BITS-1:0] delta);
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] next_idx;
    if (!playing) return 1'b0;
    if (gap_active) begin
      time_in_gap = sat_acc((ACC_W + 1)'(time_in_gap) + (ACC_W + 1)'(delta));
      if (time_in_gap < ACC_W'(sh_loop_gap)) return 1'b0;
      // Gap over: carry the excess into the frame clock.
      gap_active = 1'b0;
      time_in_frame = sat_acc((ACC_W + 1)'(time_in_frame)
                              + (ACC_W + 1)'(time_in_gap - ACC_W'(sh_loop_gap)));
      time_in_gap = '0;
    end else begin
      time_in_frame = sat_acc((ACC_W + 1)'(time_in_frame) + (ACC_W + 1)'(delta));
    end
    if (time_in_frame < ACC_W'(sh_frame_dur)) return 1'b0;
    time_in_frame = time_in_frame - ACC_W'(sh_frame_dur);
    total = sheet_total();
    next_idx = TOTAL_W'(cur_frame) + 1'b1;
    if (next_idx == total) begin
      gap_active = 1'b1;
      if (on_first_pass && !looping) begin
        restart_pass();
        playing = 1'b0;
        return notify_on_end;
      end
      on_first_pass = 1'b0;
    end
    // An index left past a shrunken sheet wraps without a loop gap.
    cur_frame = FRAME_W'(next_idx % total);
    return 1'b0;
  endfunction

  function automatic ssfs_out_t predict_frame(input ssfs_in_t cmd);
    ssfs_out_t res;
    logic [FRAME_W-1:0] col;
    logic [FRAME_W-1:0] row;
    bit fired;
    fired = 1'b0;
    case (cmd.action)
      ACT_TICK: fired = advance_clock(cmd.delta_time);
      ACT_PLAY: begin
        // Play while held restarts the pass but leaves the hold set.
        if (!playing) begin
          restart_pass();
          playing = 1'b1;
          looping = cmd.loop_request;
          notify_on_end = cmd.notify_request;
        end
      end
      ACT_PAUSE: begin
        if (playing && !paused) begin
          paused = 1'b1;
          playing = 1'b0;
        end
      end
      ACT_RESUME: begin
        if (paused) begin
          playing = 1'b1;
          paused = 1'b0;
        end
      end
      ACT_STOP: begin
        if (playing) begin
          restart_pass();
          playing = 1'b0;
          fired = cmd.notify_request;
        end
      end
      ACT_RESET: restart_pass();
      default: ;
    endcase
    col = cur_frame % FRAME_W'(sh_cols);
    row = cur_frame / FRAME_W'(sh_cols);
    res.frame_number = cur_frame;
    res.u_start = q16_edge(int'(col), int'(sh_cols));
    res.v_start = q16_edge(int'(row), int'(sh_rows));
    res.u_end = q16_edge(int'(col) + 1, int'(sh_cols));
    res.v_end = q16_edge(int'(row) + 1, int'(sh_rows));
    res.is_playing = playing;
    res.is_paused = paused;
    res.end_event = fired;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ssfs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_expect_q.size() == 0) begin
        $error("result transaction with no command waiting for it");
        fail_count++;
      end else begin
        want = frame_expect_q.pop_front();
        check_field("frame_number", 32'(want.frame_number), 32'(out_data.frame_number));
        check_field("u_start", 32'(want.u_start), 32'(out_data.u_start));
        check_field("v_start", 32'(want.v_start), 32'(out_data.v_start));
        check_field("u_end", 32'(want.u_end), 32'(out_data.u_end));
        check_field("v_end", 32'(want.v_end), 32'(out_data.v_end));
        check_field("is_playing", 32'(want.is_playing), 32'(out_data.is_playing));
        check_field("is_paused", 32'(want.is_paused), 32'(out_data.is_paused));
        check_field("end_event", 32'(want.end_event), 32'(out_data.end_event));
        frames_checked++;
        if (want.end_event) end_events++;
      end
    end
    // Stall the result channel at the phase's rate.
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one command transaction; hold valid and payload until accepted,
  // then maybe leave the channel idle for a while.
  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [TIME_BITS-1:0] delta,
                          input bit loop_req, input bit notify_req);
    ssfs_in_t cmd;
    cmd.action = act;
    cmd.delta_time = delta;
    cmd.loop_request = loop_req;
    cmd.notify_request = notify_req;
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!in_ready);
    frame_expect_q.push_back(predict_frame(cmd));
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Drop valid and wait until every predicted frame has come back.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (frame_expect_q.size() != 0) @(posedge clk);
  endtask

  // Write one register, then drop the write enable and wait with it low before returning.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CNT_W-1:0] raw_count;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    raw_count = value[CNT_W-1:0];
    case (idx)
      CFG_FRAME_DURATION: sh_frame_dur = value;
      CFG_LOOP_GAP: sh_loop_gap = value;
      CFG_COLUMN_COUNT:
        sh_cols = (raw_count == 0) ? 7'd1 : (raw_count > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS) : raw_count;
      CFG_ROW_COUNT:
        sh_rows = (raw_count == 0) ? 7'd1 : (raw_count > MAX_ROWS) ? CNT_W'(MAX_ROWS) : raw_count;
      CFG_CUT_FRAMES:
        // A cut that covers the whole sheet is stored as zero.
        sh_cut = (TOTAL_W'(value[CUT_W-1:0]) >= TOTAL_W'(sh_rows) * TOTAL_W'(sh_cols))
                 ? '0 : value[CUT_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Commands against a stopped sequencer at reset defaults: all ignored
  // except reset, no end event from stop.
  task automatic test_idle_commands();
    send_cmd(ACT_TICK, '1, 1'b1, 1'b1);
    send_cmd(ACT_PAUSE, '0, 1'b0, 1'b0);
    send_cmd(ACT_RESUME, '0, 1'b0, 1'b0);
    send_cmd(ACT_STOP, '0, 1'b0, 1'b1);
    send_cmd(ACT_SPARE_A, '0, 1'b0, 1'b0);
    send_cmd(ACT_SPARE_B, '1, 1'b1, 1'b1);
    send_cmd(ACT_RESET, '0, 1'b0, 1'b0);
    wait_quiet();
  endtask

  // Play-once pass over a 2x2 sheet with one cut frame, ending with an
  // end notification.
  task automatic test_single_pass();
    write_reg(CFG_FRAME_DURATION, 24'd5);
    write_reg(CFG_LOOP_GAP, 24'd3);
    write_reg(CFG_COLUMN_COUNT, 24'd2);
    write_reg(CFG_ROW_COUNT, 24'd2);
    write_reg(CFG_CUT_FRAMES, 24'd1);
    send_cmd(ACT_PLAY, '0, 1'b0, 1'b1);
    send_cmd(ACT_TICK, 24'd4, 1'b0, 1'b0);
    send_cmd(ACT_TICK, 24'd1, 1'b0, 1'b0);
    send_cmd(ACT_TICK, 24'd5, 1'b0, 1'b0);
    send_cmd(ACT_TICK, 24'd9, 1'b0, 1'b0);
    wait_quiet();
  endtask

  // Looping play through the gap, then hold, play while held, resume,
  // stop with notification and the reset command.
  task automatic test_loop_gap_and_hold();
    send_cmd(ACT_PLAY, '0, 1'b1, 1'b0);
    send_cmd(ACT_TICK, 24'd10, 1'b0, 1'b0);
    send_cmd(ACT_TICK, 24'd0, 1'b0, 1'b0);
    send_cmd(ACT_TICK, 24'd6, 1'b0, 1'b0);
    send_cmd(ACT_TICK, 24'd1, 1'b0, 1'b0);
    send_cmd(ACT_TICK, 24'd4, 1'b0, 1'b0);
    send_cmd(ACT_PAUSE, '0, 1'b0, 1'b0);
    send_cmd(ACT_PLAY, '0, 1'b1, 1'b1);
    send_cmd(ACT_RESUME, '0, 1'b0, 1'b0);
    send_cmd(ACT_STOP, '0, 1'b0, 1'b1);
    send_cmd(ACT_RESET, '0, 1'b0, 1'b0);
    wait_quiet();
  endtask

  // Clamped counts, oversize cut, zero duration with saturating sums, then
  // shrink the sheet under a running index.
  task automatic test_sheet_limits();
    write_reg(CFG_FRAME_DURATION, 24'd0);
    write_reg(CFG_LOOP_GAP, 24'd0);
    write_reg(CFG_COLUMN_COUNT, 24'hFFFF80);
    write_reg(CFG_ROW_COUNT, 24'h00007F);
    write_reg(CFG_CUT_FRAMES, 24'hFFFFFF);
    write_reg(CFG_SPARE, 24'hA5A5A5);
    send_cmd(ACT_PLAY, '0, 1'b1, 1'b0);
    send_cmd(ACT_TICK, '1, 1'b0, 1'b0);
    send_cmd(ACT_TICK, '1, 1'b0, 1'b0);
    send_cmd(ACT_TICK, '1, 1'b0, 1'b0);
    wait_quiet();
    // Store a cut that fits 64x64, then shrink so it no longer does.
    write_reg(CFG_COLUMN_COUNT, 24'd64);
    write_reg(CFG_CUT_FRAMES, 24'd10);
    write_reg(CFG_COLUMN_COUNT, 24'd2);
    write_reg(CFG_ROW_COUNT, 24'd1);
    send_cmd(ACT_PAUSE, '0, 1'b0, 1'b0);
    send_cmd(ACT_RESUME, '0, 1'b0, 1'b0);
    send_cmd(ACT_TICK, '0, 1'b0, 1'b0);
    send_cmd(ACT_TICK, '0, 1'b0, 1'b0);
    wait_quiet();
  endtask

  // One random phase: program the sheet, then mostly play-and-tick traffic
  // with some noise, reshaping the sheet every 40 commands.
  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input logic [TIME_BITS-1:0] dur, input logic [TIME_BITS-1:0] gap,
                                  input logic [CNT_W-1:0] cols, input logic [CNT_W-1:0] rows,
                                  input logic [CUT_W-1:0] cut);
    logic [ACT_W-1:0] act;
    logic [TIME_BITS-1:0] delta;
    int unsigned span;
    int unsigned pick;
    wait_quiet();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(CFG_FRAME_DURATION, dur);
    write_reg(CFG_LOOP_GAP, gap);
    write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'(cols));
    write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
    write_reg(CFG_CUT_FRAMES, CFG_DATA_W'(cut));
    span = (dur > gap) ? int'(dur) : int'(gap);
    for (int n = 0; n < 120; n++) begin
      if (n % 40 == 39) begin
        // Reshape the sheet mid-play; the stored cut may stop fitting.
        wait_quiet();
        write_reg(CFG_COLUMN_COUNT, ($urandom_range(9) < 7) ? CFG_DATA_W'($urandom_range(0, 6))
                                                           : CFG_DATA_W'($urandom()));
        write_reg(CFG_ROW_COUNT, ($urandom_range(9) < 7) ? CFG_DATA_W'($urandom_range(0, 6))
                                                        : CFG_DATA_W'($urandom()));
      end
      pick = $urandom_range(99);
      if (paused && pick < 40) act = ACT_RESUME;
      else if (!playing && !paused && pick < 50) act = ACT_PLAY;
      else if (pick < 75) act = ACT_TICK;
      else if (pick < 80) act = ACT_PAUSE;
      else if (pick < 84) act = ACT_RESUME;
      else if (pick < 88) act = ACT_STOP;
      else if (pick < 92) act = ACT_PLAY;
      else if (pick < 96) act = ACT_RESET;
      else act = ACT_W'($urandom_range(7));
      // Scale most ticks to the frame and gap lengths so frames move.
      pick = $urandom_range(99);
      if (pick < 10) delta = '0;
      else if (pick < 20) delta = TIME_BITS'($urandom());
      else if (pick < 24) delta = '1;
      else if (span > 32'h7FFFFF) delta = TIME_BITS'($urandom());
      else delta = TIME_BITS'($urandom_range(0, 2 * span + 1));
      send_cmd(act, delta, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    wait_quiet();
  endtask

  // Random traffic under each flow-control mix, extremes of the sheet
  // registers among the settings.
  task automatic test_random_traffic();
    run_random_phase(0, 0, 24'd4, 24'd6, 7'd3, 7'd3, 12'd2);
    run_random_phase(80, 0, 24'd0, 24'd0, 7'd5, 7'd4, 12'd17);
    run_random_phase(0, 80, 24'hFFFFFF, 24'hFFFFFF, 7'd64, 7'd64, 12'd0);
    run_random_phase(19, 19, TIME_BITS'($urandom_range(1, 30)), TIME_BITS'($urandom_range(0, 40)),
                     CNT_W'($urandom_range(1, 8)), CNT_W'($urandom_range(1, 8)),
                     CUT_W'($urandom_range(0, 20)));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_commands();
    test_single_pass();
    test_loop_gap_and_hold();
    test_sheet_limits();
    test_random_traffic();
    wait_quiet();
    // Give a stray late transaction time to show up.
    repeat (150) @(posedge clk);
    $display("%0d commands sent, %0d frames compared, %0d end events seen;",
             items_sent, frames_checked, end_events);
    $display("sheets 1x1 to 64x64, zero to full-scale timing, four idle and stall mixes");
    if (fail_count == 0) begin
      $display("sprite_sheet_frame_sequencer verification clean");
    end else begin
      $display("sprite_sheet_frame_sequencer verification failed");
    end
    $finish;
  end

endmodule
